// ----- rtl/sr_pkg.sv -----
// Shared types and constants of the systematic resampler.
package sr_pkg;

  localparam int unsigned N_MAX = 1024;

  localparam int unsigned CNT_W  = 11;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned W_W    = 32;
  localparam int unsigned OFF_W  = 16;
  localparam int unsigned CUM_W  = W_W + 1;
  localparam int unsigned PROD_W = CUM_W + CNT_W;

  localparam logic [CUM_W-1:0] ONE_Q32 = CUM_W'(1) << W_W;

  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 4;

  typedef struct packed {
    logic             first_of_round;
    logic [W_W-1:0]   weight;
    logic [OFF_W-1:0] draw_offset;
  } sr_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] particle_index;
    logic [CNT_W-1:0] copies;
    logic             round_done;
  } sr_out_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CUM_W-1:0] cum;
    logic [CNT_W-1:0] n;
    logic [OFF_W-1:0] offset;
    logic             first;
    logic             last;
  } sr_cmd_t;

endpackage

// ----- rtl/sr_front.sv -----
// Front end: accepts weights, keeps the running sum and the particle index.
module sr_front import sr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sr_in_t           in_i,
  input  logic             cfg_valid_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  input  logic             cmd_full_i,
  output logic             cmd_push_o,
  output sr_cmd_t          cmd_o
);

  logic [CUM_W-1:0] cum_q, cum_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [CNT_W-1:0] pcount_q;

  logic [CNT_W-1:0] n_eff;
  logic [CUM_W-1:0] base_cum;
  logic [CUM_W:0]   sum;
  logic [CUM_W-1:0] cum_new;
  logic [IDX_W-1:0] idx;
  logic             last;
  logic             accept;

  always_comb begin
    if (pcount_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (pcount_q > CNT_W'(N_MAX)) begin
      n_eff = CNT_W'(N_MAX);
    end else begin
      n_eff = pcount_q;
    end
  end

  always_comb begin
    accept   = push_i && !cmd_full_i;
    base_cum = in_i.first_of_round ? '0 : cum_q;
    idx      = in_i.first_of_round ? '0 : cnt_q;
    off_d    = in_i.first_of_round ? in_i.draw_offset : off_q;
    sum      = {1'b0, base_cum} + (CUM_W + 1)'(in_i.weight);
    cum_new  = (sum > {1'b0, ONE_Q32}) ? ONE_Q32 : sum[CUM_W-1:0];
    last     = ({1'b0, idx} + CNT_W'(1)) >= n_eff;
    cum_d    = last ? '0 : cum_new;
    cnt_d    = last ? '0 : idx + IDX_W'(1);

    cmd_push_o = accept;
    cmd_o.idx    = idx;
    cmd_o.cum    = cum_new;
    cmd_o.n      = n_eff;
    cmd_o.offset = off_d;
    cmd_o.first  = in_i.first_of_round;
    cmd_o.last   = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cum_q    <= '0;
      cnt_q    <= '0;
      off_q    <= '0;
      pcount_q <= CNT_W'(N_MAX);
    end else begin
      if (accept) begin
        cum_q <= cum_d;
        cnt_q <= cnt_d;
        off_q <= off_d;
      end
      if (cfg_valid_i) begin
        pcount_q <= cfg_data_i;
      end
    end
  end

endmodule

// ----- rtl/sr_cmd_fifo.sv -----
// Short command queue between the front end and the draw counter.
module sr_cmd_fifo import sr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  sr_cmd_t wdata_i,
  input  logic    rd_i,
  output sr_cmd_t rdata_o,
  output logic    full_o,
  output logic    empty_o
);

  localparam int unsigned PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CNT_QW = $clog2(CMD_DEPTH + 1);

  sr_cmd_t            mem_q [CMD_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0]  cnt_q, cnt_d;
  logic               do_wr, do_rd;

  always_comb begin
    full_o  = (cnt_q == CNT_QW'(CMD_DEPTH));
    empty_o = (cnt_q == '0);
    do_wr   = wr_i && !full_o;
    do_rd   = rd_i && !empty_o;
    rdata_o = mem_q[rd_ptr_q];
    cnt_d   = cnt_q + CNT_QW'(do_wr) - CNT_QW'(do_rd);
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/sr_back.sv -----
// Back end: draw test, copy count per particle, result queue.
module sr_back import sr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  sr_cmd_t cmd_i,
  input  logic    cmd_empty_i,
  output logic    cmd_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output sr_out_t out_o
);

  localparam int unsigned TOT_W  = PROD_W - W_W + 1;
  localparam int unsigned PTR_W  = $clog2(RES_DEPTH);
  localparam int unsigned RCNT_W = $clog2(RES_DEPTH + 1);

  // stage A: product
  logic              valid_a_q;
  logic [PROD_W-1:0] prod_q;
  logic [IDX_W-1:0]  idx_a_q;
  logic [CNT_W-1:0]  n_a_q;
  logic [OFF_W-1:0]  off_a_q;
  logic              first_a_q, last_a_q;

  logic [CNT_W-1:0]  di_q, di_d;

  sr_out_t           res_mem_q [RES_DEPTH];
  logic [PTR_W-1:0]  res_wr_q, res_rd_q;
  logic [RCNT_W-1:0] res_cnt_q, res_cnt_d;

  logic [PROD_W-1:0] base;
  logic [PROD_W-1:0] diff;
  logic [TOT_W-1:0]  total_raw;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  di_eff;
  logic [CNT_W-1:0]  copies;
  logic              res_pop;
  sr_out_t           res;

  always_comb begin
    cmd_pop_o = !cmd_empty_i &&
                ((RCNT_W + 1)'(res_cnt_q) + (RCNT_W + 1)'(valid_a_q) <
                 (RCNT_W + 1)'(RES_DEPTH));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      prod_q    <= PROD_W'(cmd_i.cum) * PROD_W'(cmd_i.n);
      idx_a_q   <= cmd_i.idx;
      n_a_q     <= cmd_i.n;
      off_a_q   <= cmd_i.offset;
      first_a_q <= cmd_i.first;
      last_a_q  <= cmd_i.last;
    end
  end

  // stage B: draws at or below the sum, minus those already issued
  always_comb begin
    base      = PROD_W'(off_a_q) << OFF_W;
    diff      = prod_q - base;
    total_raw = TOT_W'(diff[PROD_W-1:W_W]) + TOT_W'(1);
    if (prod_q < base) begin
      total = '0;
    end else if (total_raw > TOT_W'(n_a_q)) begin
      total = n_a_q;
    end else begin
      total = total_raw[CNT_W-1:0];
    end
    di_eff = first_a_q ? '0 : di_q;
    if (last_a_q) begin
      copies = (di_eff < n_a_q) ? n_a_q - di_eff : '0;
    end else begin
      copies = (total > di_eff) ? total - di_eff : '0;
    end
    di_d = last_a_q ? '0 : di_eff + copies;

    res.particle_index = idx_a_q;
    res.copies         = copies;
    res.round_done     = last_a_q;

    empty_o   = (res_cnt_q == '0);
    res_pop   = pop_i && !empty_o;
    out_o     = res_mem_q[res_rd_q];
    res_cnt_d = res_cnt_q + RCNT_W'(valid_a_q) - RCNT_W'(res_pop);
  end

  always_ff @(posedge clk_i) begin
    if (valid_a_q) begin
      res_mem_q[res_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      di_q      <= '0;
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      valid_a_q <= cmd_pop_o;
      if (valid_a_q) begin
        di_q     <= di_d;
        res_wr_q <= res_wr_q + PTR_W'(1);
      end
      if (res_pop) begin
        res_rd_q <= res_rd_q + PTR_W'(1);
      end
      res_cnt_q <= res_cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= RCNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  a_room_for_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_a_q |-> (res_cnt_q < RCNT_W'(RES_DEPTH)))
    else $error("no room for stage A beat");

  a_copies_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_a_q |-> (copies <= n_a_q))
    else $error("copy count exceeds particle count");
`endif

endmodule

// ----- rtl/systematic_resampler.sv -----
// Top level of the systematic resampler.
//
// Usage: weights enter through a queue-style port (push/full); a beat is
// taken when push is high and full is low. first_of_round marks particle 0
// of a round and carries the draw offset. Each input beat yields one result
// (particle index, copy count, round_done) on a queue-style output
// (empty/pop); the oldest result sits on out_o while empty is low.
// A beat passes the command queue, stage A and the result queue to out_o.
// Throughput: one beat per cycle while full is low, set by the running-sum
// adder of the front end and the 33x11 multiply and draw compare of the
// back end. A 4-entry command queue and a 4-entry result queue decouple
// both sides; when pop stays low the result queue fills, then the command
// queue, then full rises. particle_count is written over cfg_valid_i and
// cfg_data_i (cfg_ready_o is always high); the user must do so only while
// the block is idle, which the block does not enforce. Reset clears the
// queues, the running sum, the counters and sets particle_count to 1024.
module systematic_resampler import sr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  sr_in_t           in_i,
  output logic             empty,
  input  logic             pop,
  output sr_out_t          out_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  sr_cmd_t cmd_w, cmd_r;
  logic    cmd_push, cmd_pop, cmd_full, cmd_empty;

  assign cfg_ready_o = 1'b1;
  assign full        = cmd_full;

  sr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_w)
  );

  sr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_push),
    .wdata_i (cmd_w),
    .rd_i    (cmd_pop),
    .rdata_o (cmd_r),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  sr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_r),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_o       (out_o)
  );

endmodule
